// ===== src/dcr_pkg.sv =====
package dcr_pkg;

    localparam int CHANNELS_PER_PANEL = 2560;
    localparam int PANEL_COUNT        = 6;
    localparam int CHAN_W             = 14;
    localparam int CHAN_LIMIT         = PANEL_COUNT * CHANNELS_PER_PANEL;
    localparam int LIMIT_W            = 16;
    // highest panel index a 14-bit channel number can reach
    localparam int MAX_PANEL          = ((1 << CHAN_W) - 1) / CHANNELS_PER_PANEL;

    localparam int PLANE_U_WIRES  = 800;
    localparam int PLANE_V_WIRES  = 800;
    localparam int PLANE_Z_WIRES  = 480;
    localparam int BOARD_UV_WIRES = 40;
    localparam int BOARD_Z_WIRES  = 48;
    localparam int BOARDS_PER_PANEL = 20;

    typedef logic [1:0] t_plane;
    localparam t_plane PLANE_U  = 2'd0;
    localparam t_plane PLANE_V  = 2'd1;
    localparam t_plane PLANE_Z0 = 2'd2;
    localparam t_plane PLANE_Z1 = 2'd3;

    typedef logic [6:0] t_rom_word;

    // u wires at 0..39, v wires at 40..79, z wires at 80..127
    localparam t_rom_word WIRE_ROM [128] = '{
        7'd20, 7'd59, 7'd19, 7'd60, 7'd18, 7'd61, 7'd17, 7'd62, 7'd16, 7'd63,
        7'd4,  7'd43, 7'd3,  7'd44, 7'd2,  7'd45, 7'd1,  7'd46, 7'd0,  7'd47,
        7'd68, 7'd107, 7'd67, 7'd108, 7'd66, 7'd109, 7'd65, 7'd110, 7'd64, 7'd111,
        7'd84, 7'd123, 7'd83, 7'd124, 7'd82, 7'd125, 7'd81, 7'd126, 7'd80, 7'd127,
        7'd25, 7'd54, 7'd24, 7'd55, 7'd23, 7'd56, 7'd22, 7'd57, 7'd21, 7'd58,
        7'd9,  7'd38, 7'd8,  7'd39, 7'd7,  7'd40, 7'd6,  7'd41, 7'd5,  7'd42,
        7'd73, 7'd102, 7'd72, 7'd103, 7'd71, 7'd104, 7'd70, 7'd105, 7'd69, 7'd106,
        7'd89, 7'd118, 7'd88, 7'd119, 7'd87, 7'd120, 7'd86, 7'd121, 7'd85, 7'd122,
        7'd31, 7'd48, 7'd30, 7'd49, 7'd29, 7'd50, 7'd28, 7'd51, 7'd27, 7'd52,
        7'd26, 7'd53,
        7'd15, 7'd32, 7'd14, 7'd33, 7'd13, 7'd34, 7'd12, 7'd35, 7'd11, 7'd36,
        7'd10, 7'd37,
        7'd79, 7'd96, 7'd78, 7'd97, 7'd77, 7'd98, 7'd76, 7'd99, 7'd75, 7'd100,
        7'd74, 7'd101,
        7'd95, 7'd112, 7'd94, 7'd113, 7'd93, 7'd114, 7'd92, 7'd115, 7'd91, 7'd116,
        7'd90, 7'd117
    };

endpackage

// ===== src/detector_channel_remap.sv =====
// Offline-to-online detector channel remap.
//
// Command channel: drive i_offline_channel and raise start; the word is taken
// at every rising edge where start is high and busy is low. busy is always
// low, so a new word can be issued every cycle.
// Result channel: o_done is high for exactly one cycle per accepted word, with
// o_online_channel and o_valid_res beside it. The receiver cannot stall; the
// result must be taken in that cycle.
// Throughput is one word per cycle; each stage is registered, and the last drives o_done.
// The four pipeline stages are: panel split, plane split, board/wire split
// by constant reciprocal multiply, and board remap plus wire ROM lookup.
// An out-of-range channel gives o_valid_res = 0 and o_online_channel = 0.
// Reset (synchronous, active low) clears the stage valid bits, so nothing in
// flight at reset comes out afterwards; payload registers are not reset.
module detector_channel_remap
    import dcr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic [CHAN_W-1:0] i_offline_channel,
    output logic              busy,
    output logic              o_done,
    output logic [CHAN_W-1:0] o_online_channel,
    output logic              o_valid_res
);

    assign busy = 1'b0;

    // ---------------- stage 1: panel and panel offset
    logic        r_s1_vld, r_s1_ok;
    logic [2:0]  r_s1_panel;
    logic [11:0] r_s1_off;
    logic [2:0]  n_s1_panel;
    logic [11:0] n_s1_off;
    logic        n_s1_ok;

    always_comb begin
        n_s1_panel = '0;
        for (int k = 1; k <= MAX_PANEL; k++) begin
            if (i_offline_channel >= CHAN_W'(k * CHANNELS_PER_PANEL)) begin
                n_s1_panel = n_s1_panel + 3'd1;
            end
        end
        n_s1_off = 12'(i_offline_channel - CHAN_W'({n_s1_panel, 11'd0})
                       - CHAN_W'({n_s1_panel, 9'd0}));
        n_s1_ok  = LIMIT_W'(i_offline_channel) < LIMIT_W'(CHAN_LIMIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= start && !busy;
        end
        r_s1_ok    <= n_s1_ok;
        r_s1_panel <= n_s1_panel;
        r_s1_off   <= n_s1_off;
    end

    // ---------------- stage 2: plane split
    logic        r_s2_vld, r_s2_ok;
    logic [2:0]  r_s2_panel;
    t_plane      r_s2_plane;
    logic [9:0]  r_s2_off;
    t_plane      n_s2_plane;
    logic [9:0]  n_s2_off;

    always_comb begin
        if (r_s1_off < 12'(PLANE_U_WIRES)) begin
            n_s2_plane = PLANE_U;
            n_s2_off   = 10'(r_s1_off);
        end else if (r_s1_off < 12'(PLANE_U_WIRES + PLANE_V_WIRES)) begin
            n_s2_plane = PLANE_V;
            n_s2_off   = 10'(r_s1_off - 12'(PLANE_U_WIRES));
        end else if (r_s1_off < 12'(PLANE_U_WIRES + PLANE_V_WIRES + PLANE_Z_WIRES)) begin
            n_s2_plane = PLANE_Z0;
            n_s2_off   = 10'(r_s1_off - 12'(PLANE_U_WIRES + PLANE_V_WIRES));
        end else begin
            n_s2_plane = PLANE_Z1;
            n_s2_off   = 10'(r_s1_off
                             - 12'(PLANE_U_WIRES + PLANE_V_WIRES + PLANE_Z_WIRES));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
        r_s2_ok    <= r_s1_ok;
        r_s2_panel <= r_s1_panel;
        r_s2_plane <= n_s2_plane;
        r_s2_off   <= n_s2_off;
    end

    // ---------------- stage 3: board and wire inside plane
    logic        r_s3_vld, r_s3_ok;
    logic [2:0]  r_s3_panel;
    t_plane      r_s3_plane;
    logic [4:0]  r_s3_board;
    logic [5:0]  r_s3_wire;
    logic [14:0] n_prod40;
    logic [12:0] n_prod48;
    logic [4:0]  n_s3_board;
    logic [5:0]  n_s3_wire;

    always_comb begin
        // off/40 = (off>>3)/5 ~ *205>>10 ; off/48 = (off>>4)/3 ~ *171>>9 (exact here)
        n_prod40 = 15'(r_s2_off[9:3]) * 15'd205;
        n_prod48 = 13'(r_s2_off[9:4]) * 13'd171;
        if (r_s2_plane == PLANE_U || r_s2_plane == PLANE_V) begin
            n_s3_board = n_prod40[14:10];
            n_s3_wire  = 6'(r_s2_off - 10'({n_s3_board, 5'd0}) - 10'({n_s3_board, 3'd0}));
        end else begin
            n_s3_board = 5'(n_prod48[12:9]);
            n_s3_wire  = 6'(r_s2_off - 10'({n_s3_board, 5'd0}) - 10'({n_s3_board, 4'd0}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= r_s2_vld;
        end
        r_s3_ok    <= r_s2_ok;
        r_s3_panel <= r_s2_panel;
        r_s3_plane <= r_s2_plane;
        r_s3_board <= n_s3_board;
        r_s3_wire  <= n_s3_wire;
    end

    // ---------------- stage 4: board remap, wire flip, ROM, output
    logic        r_done, r_valid_res;
    logic [CHAN_W-1:0] r_online;
    logic        n_left;
    logic [4:0]  n_half;
    logic [4:0]  n_flip;
    logic [4:0]  n_board;
    logic [5:0]  n_wire;
    logic [6:0]  n_rom_idx;
    logic [7:0]  n_gboard;

    always_comb begin
        n_left = r_s3_panel[0];
        // (b + 10) % 20 for b < 20
        n_half = (r_s3_board < 5'd10) ? r_s3_board + 5'd10 : r_s3_board - 5'd10;
        n_flip = 5'd19 - r_s3_board;
        case (r_s3_plane)
            PLANE_U: begin
                n_board   = n_left ? r_s3_board : n_half;
                n_wire    = 6'(BOARD_UV_WIRES - 1) - r_s3_wire;
                n_rom_idx = 7'(n_wire);
            end
            PLANE_V: begin
                n_board   = n_left ? ((n_flip < 5'd10) ? n_flip + 5'd10 : n_flip - 5'd10)
                                   : n_flip;
                n_wire    = r_s3_wire;
                n_rom_idx = 7'(n_wire) + 7'(2 * BOARD_UV_WIRES / 2);
            end
            PLANE_Z0: begin
                n_board   = n_left ? 5'd9 - r_s3_board : n_flip;
                n_wire    = r_s3_wire;
                n_rom_idx = 7'(n_wire) + 7'(2 * BOARD_UV_WIRES);
            end
            default: begin
                n_board   = n_left ? r_s3_board + 5'd10 : r_s3_board;
                n_wire    = 6'(BOARD_Z_WIRES - 1) - r_s3_wire;
                n_rom_idx = 7'(n_wire) + 7'(2 * BOARD_UV_WIRES);
            end
        endcase
        // 20 * panel + board
        n_gboard = 8'({r_s3_panel, 4'd0}) + 8'({r_s3_panel, 2'd0}) + 8'(n_board);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_s3_vld;
        end
        r_valid_res <= r_s3_ok;
        r_online    <= r_s3_ok ? {n_gboard[6:0], WIRE_ROM[n_rom_idx]} : '0;
    end

    assign o_done           = r_done;
    assign o_valid_res      = r_valid_res;
    assign o_online_channel = r_online;

    // ---------------- checks
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_done)
        else $error("accepted word did not come out after 4 cycles");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, 4))
        else $error("result without a matching command");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_valid_res) |-> (o_online_channel == '0))
        else $error("out-of-range word gave nonzero channel");

    a_plane_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_vld |-> (r_s2_off < 10'(PLANE_U_WIRES)))
        else $error("plane offset out of range");

    a_board_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_vld |-> (r_s3_board < 5'(BOARDS_PER_PANEL)) && (r_s3_wire < 6'(BOARD_Z_WIRES)))
        else $error("board or wire split out of range");

endmodule
